@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset
`define CHK_IMPLY(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset
`define CHK_NEXT(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tlbpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared types for the TLB paging translator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlbpt_pkg;

	localparam int unsigned ADDR_BITS  = 16;
	localparam int unsigned PHYS_BITS  = 15;
	localparam int unsigned COUNT_BITS = 32;

	// Request to the shared minimum-search unit
	typedef struct packed {
		logic        start;
		logic        use_tlb;
	} scan_req_t;

endpackage

@@ hdl/tlbpt_min_scan.sv @@
// ----------------------------------------------------------------------------
// tlbpt_min_scan
// Shared sequential minimum search: one stamp compared per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlbpt_min_scan #(
	parameter int unsigned DEPTH      = 128,
	parameter int unsigned STAMP_BITS = 32,
	localparam int unsigned IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [IDX_BITS-1:0]   count,
	output logic [IDX_BITS-1:0]   rd_idx,
	input  logic [STAMP_BITS-1:0] rd_stamp,
	output logic                  done,
	output logic [IDX_BITS-1:0]   best_idx
);

	logic                  busy_q;
	logic                  first_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [IDX_BITS-1:0]   last_q;
	logic [IDX_BITS-1:0]   best_q;
	logic [STAMP_BITS-1:0] best_stamp_q;
	logic                  done_q;
	logic                  chk_q;
	logic                  chk_last_q;
	logic [IDX_BITS-1:0]   chk_idx_q;

	assign rd_idx   = idx_q;
	assign done     = done_q;
	assign best_idx = best_q;

	// the stamp for an index arrives in the cycle after the index is presented,
	// so the compare runs one stage behind the address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			chk_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			done_q <= chk_q && chk_last_q;
			chk_q  <= !start && busy_q;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				last_q <= count;
			end else if (busy_q) begin
				chk_idx_q  <= idx_q;
				chk_last_q <= (idx_q == last_q);
				if (idx_q == last_q) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (start) begin
				first_q <= 1'b1;
			end else if (chk_q) begin
				if (first_q || (rd_stamp < best_stamp_q)) begin
					best_stamp_q <= rd_stamp;
					best_q       <= chk_idx_q;
				end
				first_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/tlb_paging_translator_unit.sv @@
// A TLB hit goes straight to the result. A page-table hit or a fault into a free
// frame refills the TLB, through an LRU search of the TLB when it has no free or
// invalid entry; a fault with all frames used first runs an LRU search of the
// frames and evicts the victim. One word in flight at a time; the next word can be
// taken in the cycle after the result is taken. Reset clears valid bits, fill
// counts, the access clock and the totals; tables hold no reset.
// ----------------------------------------------------------------------------
// tlb_paging_translator_unit
// TLB with demand paging and LRU frame replacement, sequenced over one search unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlb_paging_translator_unit #(
	parameter int unsigned TLB_ENTRIES = 16,
	parameter int unsigned FRAME_COUNT = 128,
	parameter int unsigned PAGE_COUNT  = 256,
	parameter int unsigned PAGE_BYTES  = 256,
	parameter int unsigned STAMP_BITS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tlbpt_pkg::ADDR_BITS-1:0]     logical_address,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tlbpt_pkg::PHYS_BITS-1:0]     physical_address,
	output logic                                tlb_hit,
	output logic                                page_fault,
	output logic                                evicted,
	output logic [tlbpt_pkg::COUNT_BITS-1:0]    tlb_hit_total,
	output logic [tlbpt_pkg::COUNT_BITS-1:0]    fault_total
);

	localparam int unsigned OFF_BITS = $clog2(PAGE_BYTES);
	localparam int unsigned PG_BITS  = $clog2(PAGE_COUNT);
	localparam int unsigned FR_BITS  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int unsigned TI_BITS  = $clog2(TLB_ENTRIES);
	localparam int unsigned SI_BITS  = (FR_BITS > TI_BITS) ? FR_BITS : TI_BITS;
	localparam int unsigned PROD_BITS = FR_BITS + OFF_BITS;
	localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
	localparam logic [tlbpt_pkg::COUNT_BITS-1:0] CNT_MAX = '1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOOK, ST_PT, ST_FAULT, ST_FSCAN, ST_EVICT, ST_TINS, ST_TSCAN,
		ST_TWRITE, ST_OUT
	} state_t;

	state_t state_q;

	// TLB held in flops: searched in parallel (independent compares)
	logic [PG_BITS-1:0]    tlb_tag_q   [TLB_ENTRIES];
	logic [FR_BITS-1:0]    tlb_frame_q [TLB_ENTRIES];
	logic [STAMP_BITS-1:0] tlb_stamp_q [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] tlb_valid_q;
	logic [TI_BITS:0]      tlb_fill_q;

	// page table, frame tables
	logic [FR_BITS-1:0]    pt_frame_mem  [PAGE_COUNT];
	logic [PAGE_COUNT-1:0] pt_res_q;
	logic [PG_BITS-1:0]    fr_owner_mem  [FRAME_COUNT];
	logic [STAMP_BITS-1:0] fr_stamp_mem  [FRAME_COUNT];
	logic [FR_BITS:0]      frames_used_q;

	logic [STAMP_BITS-1:0] clock_q;
	logic [tlbpt_pkg::COUNT_BITS-1:0] hits_q, faults_q;

	logic [PG_BITS-1:0]  page_q;
	logic [OFF_BITS-1:0] off_q;
	logic [FR_BITS-1:0]  frame_q;
	logic                hit_q, fault_q, evict_q;
	logic [FR_BITS-1:0]  pt_rd_q;
	logic [PG_BITS-1:0]  owner_rd_q;

	// match search
	logic                tlb_match;
	logic [TI_BITS-1:0]  tlb_match_idx;
	logic                tlb_inv_any;
	logic [TI_BITS-1:0]  tlb_inv_idx;

	always_comb begin
		tlb_match     = 1'b0;
		tlb_match_idx = '0;
		tlb_inv_any   = 1'b0;
		tlb_inv_idx   = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (tlb_valid_q[i] && (tlb_tag_q[i] == page_q)) begin
				tlb_match     = 1'b1;
				tlb_match_idx = TI_BITS'(i);
			end
			if (!tlb_valid_q[i]) begin
				tlb_inv_any = 1'b1;
				tlb_inv_idx = TI_BITS'(i);
			end
		end
	end

	// shared search unit
	tlbpt_pkg::scan_req_t scan_req;
	logic [SI_BITS-1:0]    scan_idx, scan_best, scan_last;
	logic [STAMP_BITS-1:0] scan_stamp;
	logic                  scan_done;
	logic [STAMP_BITS-1:0] fr_stamp_rd_q;
	logic [STAMP_BITS-1:0] tlb_stamp_rd_q;
	logic                  scan_tlb_q;

	// both stamp sources are read through a register, so the unit always sees
	// the stamp in the cycle after it presents the index
	assign scan_stamp = scan_tlb_q ? tlb_stamp_rd_q : fr_stamp_rd_q;
	assign scan_last  = scan_req.use_tlb ? SI_BITS'(TLB_ENTRIES - 1) : SI_BITS'(FRAME_COUNT - 1);

	tlbpt_min_scan #(
		.DEPTH      (1 << SI_BITS),
		.STAMP_BITS (STAMP_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_req.start),
		.count    (scan_last),
		.rd_idx   (scan_idx),
		.rd_stamp (scan_stamp),
		.done     (scan_done),
		.best_idx (scan_best)
	);

	logic frame_scan_go_q;

	always_comb begin
		scan_req.start   = 1'b0;
		scan_req.use_tlb = 1'b0;
		if (state_q == ST_TINS && tlb_fill_q == (TI_BITS+1)'(TLB_ENTRIES) && !tlb_inv_any) begin
			scan_req.start   = 1'b1;
			scan_req.use_tlb = 1'b1;
		end
		if (frame_scan_go_q) begin
			scan_req.start   = 1'b1;
			scan_req.use_tlb = 1'b0;
		end
	end

	// memory read ports and writes
	logic [FR_BITS-1:0] fr_rd_idx;
	assign fr_rd_idx = (state_q == ST_FSCAN) ? scan_idx[FR_BITS-1:0] :
		(state_q == ST_FAULT) ? scan_best[FR_BITS-1:0] : frame_q;

	logic                  fr_we;
	logic [FR_BITS-1:0]    fr_wa;
	logic                  own_we;
	always_comb begin
		fr_we  = 1'b0;
		fr_wa  = frame_q;
		own_we = 1'b0;
		if (state_q == ST_LOOK && tlb_match) begin
			fr_we = 1'b1;
			fr_wa = tlb_frame_q[tlb_match_idx];
		end
		if (state_q == ST_PT && pt_res_q[page_q]) begin
			fr_we = 1'b1;
			fr_wa = pt_rd_q;
		end
		if (state_q == ST_TINS && fault_q) begin
			fr_we  = 1'b1;
			own_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		pt_rd_q        <= pt_frame_mem[page_q];
		fr_stamp_rd_q  <= fr_stamp_mem[fr_rd_idx];
		owner_rd_q     <= fr_owner_mem[fr_rd_idx];
		tlb_stamp_rd_q <= tlb_stamp_q[scan_idx[TI_BITS-1:0]];
		if (fr_we) begin
			fr_stamp_mem[fr_wa] <= clock_q;
		end
		if (own_we) begin
			fr_owner_mem[frame_q] <= page_q;
			pt_frame_mem[page_q]  <= frame_q;
		end
	end

	logic [PROD_BITS-1:0] phys_full;
	assign phys_full = {frame_q, off_q};

	// sequencer: hold one word from accept to delivery
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			tlb_valid_q     <= '0;
			tlb_fill_q      <= '0;
			pt_res_q        <= '0;
			frames_used_q   <= '0;
			clock_q         <= '0;
			hits_q          <= '0;
			faults_q        <= '0;
			frame_scan_go_q <= 1'b0;
			scan_tlb_q      <= 1'b0;
			out_valid       <= 1'b0;
		end else begin
			frame_scan_go_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						page_q  <= PG_BITS'(logical_address[tlbpt_pkg::ADDR_BITS-1:OFF_BITS]);
						off_q   <= logical_address[OFF_BITS-1:0];
						hit_q   <= 1'b0;
						fault_q <= 1'b0;
						evict_q <= 1'b0;
						if (clock_q != STAMP_MAX) begin
							clock_q <= clock_q + 1'b1;
						end
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (tlb_match) begin
						hit_q   <= 1'b1;
						frame_q <= tlb_frame_q[tlb_match_idx];
						tlb_stamp_q[tlb_match_idx] <= clock_q;
						if (hits_q != CNT_MAX) begin
							hits_q <= hits_q + 1'b1;
						end
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PT;
					end
				end
				ST_PT: begin
					if (pt_res_q[page_q]) begin
						frame_q <= pt_rd_q;
						state_q <= ST_TINS;
					end else begin
						fault_q <= 1'b1;
						if (faults_q != CNT_MAX) begin
							faults_q <= faults_q + 1'b1;
						end
						if (frames_used_q != (FR_BITS+1)'(FRAME_COUNT)) begin
							frame_q       <= frames_used_q[FR_BITS-1:0];
							frames_used_q <= frames_used_q + 1'b1;
							pt_res_q[page_q] <= 1'b1;
							state_q       <= ST_TINS;
						end else begin
							frame_scan_go_q <= 1'b1;
							scan_tlb_q      <= 1'b0;
							state_q         <= ST_FSCAN;
						end
					end
				end
				ST_FSCAN: begin
					if (scan_done) begin
						state_q <= ST_FAULT;
					end
				end
				ST_FAULT: begin
					// owner read of the victim frame issues this cycle
					frame_q <= scan_best[FR_BITS-1:0];
					state_q <= ST_EVICT;
				end
				ST_EVICT: begin
					evict_q <= 1'b1;
					pt_res_q[owner_rd_q] <= 1'b0;
					for (int i = 0; i < TLB_ENTRIES; i++) begin
						if (tlb_valid_q[i] && tlb_tag_q[i] == owner_rd_q) begin
							tlb_valid_q[i] <= 1'b0;
						end
					end
					state_q <= ST_TWRITE;
				end
				ST_TWRITE: begin
					pt_res_q[page_q] <= 1'b1;
					state_q <= ST_TINS;
				end
				ST_TINS: begin
					if (tlb_fill_q != (TI_BITS+1)'(TLB_ENTRIES)) begin
						tlb_fill_q <= tlb_fill_q + 1'b1;
						state_q    <= ST_OUT;
						tlb_tag_q[tlb_fill_q[TI_BITS-1:0]]   <= page_q;
						tlb_frame_q[tlb_fill_q[TI_BITS-1:0]] <= frame_q;
						tlb_stamp_q[tlb_fill_q[TI_BITS-1:0]] <= clock_q;
						tlb_valid_q[tlb_fill_q[TI_BITS-1:0]] <= 1'b1;
					end else if (tlb_inv_any) begin
						tlb_tag_q[tlb_inv_idx]   <= page_q;
						tlb_frame_q[tlb_inv_idx] <= frame_q;
						tlb_stamp_q[tlb_inv_idx] <= clock_q;
						tlb_valid_q[tlb_inv_idx] <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						scan_tlb_q <= 1'b1;
						state_q    <= ST_TSCAN;
					end
				end
				ST_TSCAN: begin
					if (scan_done) begin
						tlb_tag_q[scan_best[TI_BITS-1:0]]   <= page_q;
						tlb_frame_q[scan_best[TI_BITS-1:0]] <= frame_q;
						tlb_stamp_q[scan_best[TI_BITS-1:0]] <= clock_q;
						tlb_valid_q[scan_best[TI_BITS-1:0]] <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid) begin
						out_valid        <= 1'b1;
						physical_address <= tlbpt_pkg::PHYS_BITS'(phys_full);
						tlb_hit          <= hit_q;
						page_fault       <= fault_q;
						evicted          <= evict_q;
						tlb_hit_total    <= hits_q;
						fault_total      <= faults_q;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

@@ hdl/tlbpt_checker.sv @@
// ----------------------------------------------------------------------------
// tlbpt_checker
// Port-level checks on the translator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlbpt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        tlb_hit,
	input logic        page_fault,
	input logic        evicted,
	input logic [31:0] fault_total
);

	`CHK_IMPLY(a_hit_no_fault, arst_n, out_valid, !(tlb_hit && page_fault), "hit and fault together")
	`CHK_IMPLY(a_evict_fault, arst_n, out_valid && evicted, page_fault, "eviction without fault")
	`CHK_IMPLY(a_busy_out, arst_n, out_valid, in_stall, "input open while a word waits")
	`CHK_NEXT(a_hold, arst_n, out_valid && out_stall, out_valid && $stable(fault_total), "stalled word changed")

endmodule

bind tlb_paging_translator_unit tlbpt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .tlb_hit(tlb_hit), .page_fault(page_fault),
	.evicted(evicted), .fault_total(fault_total)
);

@@ tb/tlb_paging_translator_unit_test.sv @@
// ----------------------------------------------------------------------------
// tlb_paging_translator_unit_test
// Self-checking bench: a directed table of addresses, then random traffic
// shaped around a small working set. The bench keeps its own copy of the TLB,
// the page table and the frame table, predicts each result word, and compares
// every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlb_paging_translator_unit_test;

	localparam int TLB_N     = 16;
	localparam int FRAME_N   = 128;
	localparam int PAGE_N    = 256;
	localparam int RAND_N    = 750;
	localparam int LIMIT_CYC = 2000000;

	typedef struct packed {
		logic [tlbpt_pkg::PHYS_BITS-1:0]  phys;
		logic                             hit;
		logic                             fault;
		logic                             evict;
		logic [tlbpt_pkg::COUNT_BITS-1:0] hits;
		logic [tlbpt_pkg::COUNT_BITS-1:0] faults;
	} xlate_t;

	// Directed row: address, and a typed-in result where it is obvious
	typedef struct {
		logic [15:0] addr;
		bit          known;
		xlate_t      want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [tlbpt_pkg::ADDR_BITS-1:0] logical_address = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [tlbpt_pkg::PHYS_BITS-1:0] physical_address;
	logic tlb_hit, page_fault, evicted;
	logic [tlbpt_pkg::COUNT_BITS-1:0] tlb_hit_total, fault_total;

	tlb_paging_translator_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .logical_address(logical_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.physical_address(physical_address), .tlb_hit(tlb_hit), .page_fault(page_fault),
		.evicted(evicted), .tlb_hit_total(tlb_hit_total), .fault_total(fault_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: a private mirror of the translator
	logic [7:0]  tag_q [TLB_N];
	logic [6:0]  tframe_q [TLB_N];
	bit          tvalid_q [TLB_N];
	logic [31:0] tstamp_q [TLB_N];
	int          tfill_q;
	logic [6:0]  pframe_q [PAGE_N];
	bit          resident_q [PAGE_N];
	logic [7:0]  owner_q [FRAME_N];
	logic [31:0] fstamp_q [FRAME_N];
	int          frames_used_q;
	logic [31:0] clock_q, hits_q, faults_q;

	xlate_t expected_words[$];
	int     errors = 0;
	longint cycles = 0;
	bit     idle_free = 1'b0;  // set to hold both sides busy for a stretch

	function automatic void tlb_fill(logic [7:0] pg, logic [6:0] fr);
		int slot;
		bit found;
		slot = 0;
		found = 1'b0;
		if (tfill_q < TLB_N) begin
			slot = tfill_q;
			tfill_q++;
		end else begin
			for (int i = 0; i < TLB_N; i++)
				if (!found && !tvalid_q[i]) begin
					slot = i;
					found = 1'b1;
				end
			if (!found)
				for (int i = 1; i < TLB_N; i++)
					if (tstamp_q[i] < tstamp_q[slot]) slot = i;
		end
		tag_q[slot] = pg;
		tframe_q[slot] = fr;
		tvalid_q[slot] = 1'b1;
		tstamp_q[slot] = clock_q;
	endfunction

	function automatic xlate_t translate(logic [15:0] addr);
		xlate_t r;
		logic [7:0] pg, victim;
		logic [6:0] fr;
		bit hit;
		pg = addr[15:8];
		fr = '0;
		hit = 1'b0;
		r = '0;
		if (clock_q != 32'hFFFF_FFFF) clock_q++;
		for (int i = 0; i < TLB_N; i++)
			if (!hit && tvalid_q[i] && tag_q[i] == pg) begin
				hit = 1'b1;
				fr = tframe_q[i];
				tstamp_q[i] = clock_q;
			end
		if (hit) begin
			if (hits_q != 32'hFFFF_FFFF) hits_q++;
			fstamp_q[fr] = clock_q;
		end else if (resident_q[pg]) begin
			fr = pframe_q[pg];
			fstamp_q[fr] = clock_q;
			tlb_fill(pg, fr);
		end else begin
			r.fault = 1'b1;
			if (faults_q != 32'hFFFF_FFFF) faults_q++;
			if (frames_used_q < FRAME_N) begin
				fr = 7'(frames_used_q);
				frames_used_q++;
			end else begin
				// least recently used frame, lowest index on a tie
				for (int i = 1; i < FRAME_N; i++)
					if (fstamp_q[i] < fstamp_q[fr]) fr = 7'(i);
				victim = owner_q[fr];
				r.evict = 1'b1;
				resident_q[victim] = 1'b0;
				for (int i = 0; i < TLB_N; i++)
					if (tvalid_q[i] && tag_q[i] == victim) tvalid_q[i] = 1'b0;
			end
			pframe_q[pg] = fr;
			resident_q[pg] = 1'b1;
			owner_q[fr] = pg;
			fstamp_q[fr] = clock_q;
			tlb_fill(pg, fr);
		end
		r.phys = {fr, addr[7:0]};
		r.hit = hit;
		r.hits = hits_q;
		r.faults = faults_q;
		return r;
	endfunction

	// Send one word: hold it until accepted, then predict
	task automatic send_word(logic [15:0] addr, bit known, xlate_t want);
		xlate_t p;
		while (!idle_free && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		logical_address <= addr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		p = translate(addr);
		if (known && p != want)
			$display("%0t: table row %h disagrees with predictor: %h vs %h",
				$time, addr, want, p);
		expected_words.push_back(known ? want : p);
	endtask

	// Receiver: stall at random, check each accepted word
	always @(posedge clk) begin
		xlate_t got, want;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			got = '{physical_address, tlb_hit, page_fault, evicted,
				tlb_hit_total, fault_total};
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word %h", $time, got);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (got.phys != want.phys) begin
					$display("%0t: physical_address exp %h got %h", $time, want.phys, got.phys);
					errors++;
				end
				if (got.hit != want.hit) begin
					$display("%0t: tlb_hit exp %b got %b", $time, want.hit, got.hit);
					errors++;
				end
				if (got.fault != want.fault) begin
					$display("%0t: page_fault exp %b got %b", $time, want.fault, got.fault);
					errors++;
				end
				if (got.evict != want.evict) begin
					$display("%0t: evicted exp %b got %b", $time, want.evict, got.evict);
					errors++;
				end
				if (got.hits != want.hits) begin
					$display("%0t: tlb_hit_total exp %0d got %0d", $time, want.hits, got.hits);
					errors++;
				end
				if (got.faults != want.faults) begin
					$display("%0t: fault_total exp %0d got %0d", $time, want.faults,
						got.faults);
					errors++;
				end
			end
		end
		out_stall <= !idle_free && ($urandom_range(99) < 24);
	end

	// Hard stop on a hang
	always @(posedge clk) begin
		if (cycles == LIMIT_CYC) begin
			$display("tlb_paging_translator_unit: mismatch");
			$finish;
		end
	end

	row_t rows[$];

	function automatic xlate_t mk(logic [14:0] ph, bit h, bit f, int nh, int nf);
		xlate_t r;
		r = '{ph, h, f, 1'b0, 32'(nh), 32'(nf)};
		return r;
	endfunction

	initial begin
		logic [15:0] addr;
		int hot[12];
		int pick;
		tvalid_q = '{default: 1'b0};
		resident_q = '{default: 1'b0};
		tfill_q = 0;
		frames_used_q = 0;
		clock_q = '0;
		hits_q = '0;
		faults_q = '0;

		// Obvious results right after reset: first fault goes to frame 0
		rows.push_back('{16'h0000, 1'b1, mk(15'h0000, 0, 1, 0, 1)});
		rows.push_back('{16'h00FF, 1'b1, mk(15'h00FF, 1, 0, 1, 1)});
		rows.push_back('{16'hFFFF, 1'b1, mk(15'h01FF, 0, 1, 1, 2)});
		rows.push_back('{16'hFF00, 1'b1, mk(15'h0100, 1, 0, 2, 2)});
		rows.push_back('{16'h5AA5, 1'b1, mk(15'h02A5, 0, 1, 2, 3)});
		rows.push_back('{16'hA55A, 1'b1, mk(15'h035A, 0, 1, 2, 4)});
		// Fill more than the TLB holds: each of these pages faults, and later ones need LRU TLB refills
		for (int p = 1; p <= 20; p++) rows.push_back('{16'(p << 8) | 16'(p), 1'b0, '0});

		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_word(rows[i].addr, rows[i].known, rows[i].want);

		// Random: mostly a shifting hot set so the TLB hits and frames run out,
		// so LRU eviction and TLB invalidation are reached; some pure noise
		for (int k = 0; k < 12; k++) hot[k] = $urandom_range(255);
		for (int n = 0; n < RAND_N; n++) begin
			idle_free = (n >= 300 && n < 400);
			if ($urandom_range(9) == 0) hot[$urandom_range(11)] = $urandom_range(255);
			pick = $urandom_range(99);
			if (pick < 55)
				addr = {8'(hot[$urandom_range(11)]), 8'($urandom)};
			else
				addr = 16'($urandom);
			send_word(addr, 1'b0, '0);
		end
		in_valid <= 1'b0;
		idle_free = 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tlb_paging_translator_unit: match");
		else
			$display("tlb_paging_translator_unit: mismatch");
		$finish;
	end

endmodule
